FILE: rtl/nlc_pkg.sv
// Package with the phase and class codes and the character step function of the classifier.
`timescale 1ns / 1ps

package nlc_pkg;

  localparam int PhaseW = 4;
  localparam int ClassW = 2;

  localparam logic [PhaseW-1:0] PH_START     = 4'd0;
  localparam logic [PhaseW-1:0] PH_ZERO      = 4'd1;
  localparam logic [PhaseW-1:0] PH_INT       = 4'd2;
  localparam logic [PhaseW-1:0] PH_FRAC      = 4'd3;
  localparam logic [PhaseW-1:0] PH_EXP_SIGN  = 4'd4;
  localparam logic [PhaseW-1:0] PH_EXP_DIG   = 4'd5;
  localparam logic [PhaseW-1:0] PH_HEX_START = 4'd6;
  localparam logic [PhaseW-1:0] PH_HEX_DIG   = 4'd7;
  localparam logic [PhaseW-1:0] PH_DONE      = 4'd8;

  localparam logic [ClassW-1:0] CLS_INVALID = 2'd0;
  localparam logic [ClassW-1:0] CLS_INT     = 2'd1;
  localparam logic [ClassW-1:0] CLS_HEX     = 2'd2;
  localparam logic [ClassW-1:0] CLS_DOUBLE  = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [ClassW-1:0] cls;
  } scan_state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } scan_word_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  function automatic logic is_stop(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_NUL);
  endfunction

  // One character applied to the scan state. The start and leading-zero phases
  // fall through into the integer phase for characters they do not consume.
  function automatic scan_state_t scan_next(input scan_state_t cur, input logic [7:0] c);
    scan_state_t       nxt;
    logic [PhaseW-1:0] eff;
    logic              taken;
    nxt   = cur;
    eff   = cur.phase;
    taken = 1'b0;
    if (cur.phase == PH_START) begin
      if (c == CH_MINUS) begin
        nxt.phase = PH_INT;
        taken     = 1'b1;
      end else if (c == CH_ZERO) begin
        nxt.phase = PH_ZERO;
        taken     = 1'b1;
      end else begin
        eff = PH_INT;
      end
    end else if (cur.phase == PH_ZERO) begin
      if ((c == CH_LX) || (c == CH_UX)) begin
        nxt.phase = PH_HEX_START;
        taken     = 1'b1;
      end else begin
        eff = PH_INT;
      end
    end
    if (!taken) begin
      nxt.phase = eff;
      unique case (eff)
        PH_INT: begin
          if (c == CH_DOT) nxt.phase = PH_FRAC;
          else if (c == CH_LE) nxt.phase = PH_EXP_SIGN;
          else if (!is_dec(c)) begin
            nxt.phase = PH_DONE;
            nxt.cls   = is_stop(c) ? CLS_INT : CLS_INVALID;
          end
        end
        PH_FRAC: begin
          if (c == CH_LE) nxt.phase = PH_EXP_SIGN;
          else if (!is_dec(c)) begin
            nxt.phase = PH_DONE;
            nxt.cls   = is_stop(c) ? CLS_DOUBLE : CLS_INVALID;
          end
        end
        PH_EXP_SIGN: begin
          if ((c == CH_PLUS) || (c == CH_MINUS) || is_dec(c)) nxt.phase = PH_EXP_DIG;
          else begin
            nxt.phase = PH_DONE;
            nxt.cls   = is_stop(c) ? CLS_DOUBLE : CLS_INVALID;
          end
        end
        PH_EXP_DIG: begin
          if (!is_dec(c)) begin
            nxt.phase = PH_DONE;
            nxt.cls   = is_stop(c) ? CLS_DOUBLE : CLS_INVALID;
          end
        end
        PH_HEX_START: begin
          if (is_hex(c)) nxt.phase = PH_HEX_DIG;
          else begin
            nxt.phase = PH_DONE;
            nxt.cls   = CLS_INVALID;
          end
        end
        PH_HEX_DIG: begin
          if (!is_hex(c)) begin
            nxt.phase = PH_DONE;
            nxt.cls   = is_stop(c) ? CLS_HEX : CLS_INVALID;
          end
        end
        PH_DONE: begin
          nxt.phase = PH_DONE;
        end
        default: begin
          nxt.phase = PH_DONE;
          nxt.cls   = CLS_INVALID;
        end
      endcase
    end
    return nxt;
  endfunction

endpackage

FILE: rtl/numeric_literal_classifier.sv
// Top level of the numeric literal classifier: input register, scanner and result register.
`timescale 1ns / 1ps

// The classifier takes a token one character word per cycle, followed by an end
// word, and returns one number_class word for each end word: 0 invalid, 1 decimal
// integer, 2 hexadecimal, 3 floating double. Character words produce no result.
// Each accepted word is held in an input register, from which a single character
// step updates the scan state; for an end word the class is loaded into the result
// register. The sustained rate is one word per cycle while in_ready stays high.
// A waiting result does not block the input: character words keep flowing while
// the result register is full, and only an end word that meets a full, stalled
// result register holds the input register and lowers in_ready.
module numeric_literal_classifier
  import nlc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        ch,
  input  logic              is_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ClassW-1:0] number_class
);

  logic              hold_valid;
  scan_word_t        hold_word;
  logic              advance;
  logic [ClassW-1:0] result_class;

  // A character word never needs the result register; an end word needs it free
  // or being emptied in this cycle.
  assign advance  = hold_valid && (!hold_word.is_end || !out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  // The held word needs no reset; it is only used while hold_valid is set.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_word.ch     <= ch;
      hold_word.is_end <= is_end;
    end
  end

  nlc_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .word         (hold_word),
    .result_class (result_class)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && hold_word.is_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_word.is_end) begin
      number_class <= result_class;
    end
  end

endmodule

FILE: rtl/nlc_scan.sv
// Scan state register and the character step that classifies a token.
`timescale 1ns / 1ps

module nlc_scan
  import nlc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  scan_word_t        word,
  output logic [ClassW-1:0] result_class
);

  scan_state_t state;
  scan_state_t state_next;
  scan_state_t stepped;

  // The end word acts like a zero byte, which closes any open scan.
  always_comb begin
    stepped      = scan_next(state, word.is_end ? CH_NUL : word.ch);
    result_class = stepped.cls;
    state_next   = state;
    if (step) begin
      if (word.is_end) begin
        state_next.phase = PH_START;
        state_next.cls   = CLS_INVALID;
      end else begin
        state_next = stepped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= PH_START;
      state.cls   <= CLS_INVALID;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/nlc_checker.sv
// Port-level checker for the numeric literal classifier and its bind.
`timescale 1ns / 1ps

module nlc_checker
  import nlc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [7:0]        ch,
  input logic              is_end,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ClassW-1:0] number_class
);

  // A stalled result word holds its value.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(number_class)))
    else $error("result word changed while stalled");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending right after reset");

  // The input only stalls behind a full result register.
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

  // A new result word is loaded from an end word held in the input register.
  // That word was either just accepted, or was already held there
  // while the input was stalled.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(in_valid && in_ready && is_end, 2) || $past(!in_ready, 2)))
    else $error("result appeared without a preceding end word");

endmodule

bind numeric_literal_classifier nlc_checker u_nlc_checker (.*);

FILE: dv/nlc_checker.sv
// Checker for the numeric literal classifier: predicts each token class and compares results.
`timescale 1ns / 1ps

module nlc_class_checker
  import nlc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        ch,
  input  logic              is_end,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [ClassW-1:0] number_class,
  output int unsigned       fails,
  output int unsigned       outstanding,
  output int unsigned       results_seen
);

  localparam scan_state_t TOKEN_START = '{phase: PH_START, cls: CLS_INVALID};

  scan_state_t       scan = TOKEN_START;
  logic [ClassW-1:0] pending_classes[$];
  logic [ClassW-1:0] want;
  int unsigned       fail_n = 0;
  int unsigned       seen_n = 0;

  // Applies one character to the predicted scan state. The start and
  // leading-zero phases hand characters they do not consume to the integer phase.
  function automatic scan_state_t advance_scan(input scan_state_t s, input logic [7:0] c);
    scan_state_t n;
    logic        digit;
    logic        hex_digit;
    logic        stop;
    n         = s;
    digit     = (c >= CH_ZERO) && (c <= CH_NINE);
    hex_digit = digit || ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
    stop      = (c == CH_SPACE) || (c == CH_NUL);
    if (n.phase == PH_START) begin
      if (c == CH_MINUS) begin
        n.phase = PH_INT;
        return n;
      end
      if (c == CH_ZERO) begin
        n.phase = PH_ZERO;
        return n;
      end
      n.phase = PH_INT;
    end else if (n.phase == PH_ZERO) begin
      if ((c == CH_LX) || (c == CH_UX)) begin
        n.phase = PH_HEX_START;
        return n;
      end
      n.phase = PH_INT;
    end
    case (n.phase)
      PH_INT: begin
        if (c == CH_DOT) n.phase = PH_FRAC;
        else if (c == CH_LE) n.phase = PH_EXP_SIGN;
        else if (!digit) begin
          n.phase = PH_DONE;
          n.cls   = stop ? CLS_INT : CLS_INVALID;
        end
      end
      PH_FRAC: begin
        if (c == CH_LE) n.phase = PH_EXP_SIGN;
        else if (!digit) begin
          n.phase = PH_DONE;
          n.cls   = stop ? CLS_DOUBLE : CLS_INVALID;
        end
      end
      PH_EXP_SIGN: begin
        if ((c == CH_PLUS) || (c == CH_MINUS) || digit) n.phase = PH_EXP_DIG;
        else begin
          n.phase = PH_DONE;
          n.cls   = stop ? CLS_DOUBLE : CLS_INVALID;
        end
      end
      PH_EXP_DIG: begin
        if (!digit) begin
          n.phase = PH_DONE;
          n.cls   = stop ? CLS_DOUBLE : CLS_INVALID;
        end
      end
      PH_HEX_START: begin
        if (hex_digit) n.phase = PH_HEX_DIG;
        else begin
          n.phase = PH_DONE;
          n.cls   = CLS_INVALID;
        end
      end
      PH_HEX_DIG: begin
        if (!hex_digit) begin
          n.phase = PH_DONE;
          n.cls   = stop ? CLS_HEX : CLS_INVALID;
        end
      end
      PH_DONE: begin
        n.phase = PH_DONE;
      end
      default: begin
        n.phase = PH_DONE;
        n.cls   = CLS_INVALID;
      end
    endcase
    return n;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      scan = TOKEN_START;
      pending_classes.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen_n++;
        if (pending_classes.size() == 0) begin
          fail_n++;
          $display("%0t: unexpected number_class word, expected none, actual %0d",
                   $time, number_class);
        end else begin
          want = pending_classes.pop_front();
          if (number_class !== want) begin
            fail_n++;
            $display("%0t: number_class mismatch, expected %0d, actual %0d",
                     $time, want, number_class);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (is_end) begin
          // The end word closes the scan as a zero byte would.
          scan = advance_scan(scan, CH_NUL);
          pending_classes.push_back(scan.cls);
          scan = TOKEN_START;
        end else begin
          scan = advance_scan(scan, ch);
        end
      end
    end
    fails        <= fail_n;
    outstanding  <= pending_classes.size();
    results_seen <= seen_n;
  end

endmodule

FILE: dv/tb.sv
// Top of the classifier testbench: clock, reset, token stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb;
  import nlc_pkg::*;

  // The run moves through three modes. In the idle mode both sides pause at
  // random. The flood mode sends words back to back while the receiver takes
  // one long hold-off, so the result register fills and end words stall the
  // input. The steady mode at the end has no pauses on either side.
  typedef enum logic [1:0] {RUN_IDLE, RUN_FLOOD, RUN_STEADY} run_mode_e;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned WORD_TARGET  = 650;
  localparam int unsigned FLOOD_FROM   = 260;
  localparam int unsigned FLOOD_TO     = 380;
  localparam int unsigned STEADY_FROM  = 560;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        ch;
  logic              is_end;
  logic              out_valid;
  logic              out_ready;
  logic [ClassW-1:0] number_class;

  int unsigned fails;
  int unsigned outstanding;
  int unsigned results_seen;
  int unsigned cycle_count = 0;
  int unsigned words_sent  = 0;
  int unsigned tokens_sent = 0;
  run_mode_e   run_mode;

  // Characters of the token that is about to be sent.
  logic [7:0] lit_chars[$];

  numeric_literal_classifier DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .ch           (ch),
    .is_end       (is_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .number_class (number_class)
  );

  nlc_class_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .ch           (ch),
    .is_end       (is_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .number_class (number_class),
    .fails        (fails),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // A hung handshake ends the run here rather than running forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results still due", cycle_count, outstanding);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_hex_digit();
    case ($urandom_range(0, 2))
      0:       return CH_LA + 8'($urandom_range(0, 5));
      1:       return CH_UA + 8'($urandom_range(0, 5));
      default: return pick_digit();
    endcase
  endfunction

  // Offers one word and holds it until the classifier takes it. In the idle
  // mode a random pause may follow; valid is dropped for its length.
  task automatic send_word(input logic [7:0] c, input logic e);
    in_valid <= 1'b1;
    ch       <= c;
    is_end   <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if ((run_mode == RUN_IDLE) && ($urandom_range(0, 3) == 0)) begin
      in_valid <= 1'b0;
      ch       <= 8'($urandom);
      is_end   <= 1'($urandom);
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Sends the queued characters and closes the token with an end word. The
  // end word carries a random byte, which the classifier must ignore.
  task automatic send_literal();
    foreach (lit_chars[i]) send_word(lit_chars[i], 1'b0);
    send_word(8'($urandom), 1'b1);
    tokens_sent++;
  endtask

  task automatic send_text(input string s);
    lit_chars.delete();
    for (int i = 0; i < s.len(); i++) lit_chars.push_back(s[i]);
    send_literal();
  endtask

  // Most tokens are well formed integers, hex values or doubles with random
  // content, so the deeper phases are reached often. About one in five is raw
  // byte noise, and some tokens get one byte corrupted or an early stop
  // followed by trailing junk.
  task automatic build_random_literal();
    int unsigned kind;
    int unsigned spot;
    lit_chars.delete();
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      if ($urandom_range(0, 3) == 0) lit_chars.push_back(CH_MINUS);
      repeat ($urandom_range(1, 5)) lit_chars.push_back(pick_digit());
    end else if (kind <= 4) begin
      lit_chars.push_back(CH_ZERO);
      lit_chars.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
      repeat ($urandom_range(0, 4)) lit_chars.push_back(pick_hex_digit());
    end else if (kind <= 7) begin
      if ($urandom_range(0, 3) == 0) lit_chars.push_back(CH_MINUS);
      repeat ($urandom_range(0, 3)) lit_chars.push_back(pick_digit());
      if ($urandom_range(0, 2) != 0) begin
        lit_chars.push_back(CH_DOT);
        repeat ($urandom_range(0, 3)) lit_chars.push_back(pick_digit());
      end
      if ($urandom_range(0, 2) != 0) begin
        lit_chars.push_back(CH_LE);
        case ($urandom_range(0, 2))
          0:       lit_chars.push_back(CH_PLUS);
          1:       lit_chars.push_back(CH_MINUS);
          default: ;
        endcase
        repeat ($urandom_range(0, 3)) lit_chars.push_back(pick_digit());
      end
    end else begin
      repeat ($urandom_range(1, 6)) lit_chars.push_back(8'($urandom));
    end
    case ($urandom_range(0, 5))
      0: begin
        if (lit_chars.size() > 0) begin
          spot = $urandom_range(0, lit_chars.size() - 1);
          lit_chars[spot] = 8'($urandom);
        end
      end
      1: begin
        lit_chars.push_back($urandom_range(0, 1) ? CH_SPACE : CH_NUL);
        repeat ($urandom_range(0, 3)) lit_chars.push_back(8'($urandom));
      end
      default: ;
    endcase
  endtask

  // Receiver side. It stalls in random bursts in the idle mode, takes a single
  // long hold-off when the flood starts, and stays ready in the steady mode.
  initial begin : receiver
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ((run_mode == RUN_FLOOD) && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (run_mode == RUN_STEADY) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    rst      <= 1'b1;
    in_valid <= 1'b0;
    ch       <= CH_NUL;
    is_end   <= 1'b0;
    run_mode <= RUN_IDLE;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed tokens: an empty token and a lone minus both count as integers,
    // a lone dot after a minus is a double, as is an exponent with no digits.
    send_text("");
    send_text("-");
    send_text("-.");
    send_text("1e+");
    // A hex prefix with no digits is invalid, a leading zero stays decimal,
    // and a minus before a hex prefix makes the token invalid.
    send_text("0x");
    send_text("05");
    send_text("-0x1");
    // A zero byte stops the scan like a space, so the junk after it is ignored.
    lit_chars = '{"1", CH_NUL, "z"};
    send_literal();
    // The top byte value is not part of the grammar.
    lit_chars = '{8'hFF};
    send_literal();

    while (words_sent < WORD_TARGET) begin
      if (words_sent >= STEADY_FROM) run_mode <= RUN_STEADY;
      else if ((words_sent >= FLOOD_FROM) && (words_sent < FLOOD_TO)) run_mode <= RUN_FLOOD;
      else run_mode <= RUN_IDLE;
      build_random_literal();
      send_literal();
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d tokens in %0d words and %0d checked classes, with random stalls",
             tokens_sent, words_sent, results_seen);
    $display("on both sides and a %0d-cycle output hold-off under back-to-back input.",
             HOLD_CYCLES);
    if ((fails == 0) && (outstanding == 0)) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
